// ----- design/sbst_pkg.sv -----
// Shared types and constants for the segment versus box slab test.
// No dependencies; the lane, merge and top-level design files refer to this package.
package sbst_pkg;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_LOW_X  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_LOW_Y  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_LOW_Z  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_HIGH_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_HIGH_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_HIGH_Z = 3'd5;

   localparam int NUM_AXES = 3;

   // Per-axis status: active means the segment moves along the axis,
   // ok means the axis alone does not rule out a hit.
   typedef struct packed {
      logic active;
      logic ok;
   } lane_flags_type;

endpackage

// ----- design/sbst_lane.sv -----
// One axis lane: forms the slab entry and exit numerators and the common
// denominator for one axis, registered. Depends on sbst_pkg.
module sbst_lane #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [COORD_WIDTH-1:0] box_low,
   input  logic signed [COORD_WIDTH-1:0] box_high,
   input  logic signed [COORD_WIDTH-1:0] start_coord,
   input  logic signed [COORD_WIDTH-1:0] end_coord,
   output logic signed [COORD_WIDTH:0]   n_in_ff,
   output logic signed [COORD_WIDTH:0]   n_out_ff,
   output logic        [COORD_WIDTH:0]   den_ff,
   output sbst_pkg::lane_flags_type      flags_ff
);

   localparam int NW = COORD_WIDTH + 1;

   logic signed [NW-1:0] lo_x, hi_x, s_x, e_x, dir;
   logic signed [NW-1:0] n_in_in, n_out_in, neg_dir;
   logic        [NW-1:0] den_in;
   logic                 box_bad;
   sbst_pkg::lane_flags_type flags_in;

   always_comb begin
      lo_x    = NW'(box_low);
      hi_x    = NW'(box_high);
      s_x     = NW'(start_coord);
      e_x     = NW'(end_coord);
      dir     = e_x - s_x;
      neg_dir = -dir;
      box_bad = lo_x > hi_x;
      if (dir == '0) begin
         flags_in.active = 1'b0;
         flags_in.ok     = !box_bad && (s_x >= lo_x) && (s_x <= hi_x);
      end else begin
         flags_in.active = 1'b1;
         flags_in.ok     = !box_bad;
      end
      // A direction of -2^COORD_WIDTH negates to the same bit pattern,
      // which read unsigned is the right magnitude.
      if (!dir[NW-1]) begin
         n_in_in  = lo_x - s_x;
         n_out_in = hi_x - s_x;
         den_in   = dir;
      end else begin
         n_in_in  = s_x - hi_x;
         n_out_in = s_x - lo_x;
         den_in   = neg_dir;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n_in_ff  <= n_in_in;
         n_out_ff <= n_out_in;
         den_ff   <= den_in;
         flags_ff <= flags_in;
      end
   end

endmodule

// ----- design/sbst_merge.sv -----
// Merge stage: cross-multiplies every entry parameter against every exit
// parameter of the three lanes, in split partial products, and decides hit.
// Depends on sbst_pkg.
module sbst_merge #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    enable_mul,
   input  logic                                    enable_cmp,
   input  logic signed [sbst_pkg::NUM_AXES-1:0][COORD_WIDTH:0] n_in,
   input  logic signed [sbst_pkg::NUM_AXES-1:0][COORD_WIDTH:0] n_out,
   input  logic        [sbst_pkg::NUM_AXES-1:0][COORD_WIDTH:0] den,
   input  sbst_pkg::lane_flags_type [sbst_pkg::NUM_AXES-1:0]   flags,
   output logic                                    hit_ff
);

   localparam int AX = sbst_pkg::NUM_AXES;
   localparam int NW = COORD_WIDTH + 1;
   localparam int DW = COORD_WIDTH + 1;
   localparam int H  = DW / 2;
   localparam int HH = DW - H;
   localparam int LW = NW + H + 1;
   localparam int UW = NW + HH + 1;
   localparam int PW = NW + DW + 2;

   // Partial products: [i][j] pairs entry of lane i with exit of lane j.
   logic signed [LW-1:0] lhs_lo_ff [AX][AX];
   logic signed [UW-1:0] lhs_hi_ff [AX][AX];
   logic signed [LW-1:0] rhs_lo_ff [AX][AX];
   logic signed [UW-1:0] rhs_hi_ff [AX][AX];
   logic [AX-1:0]        active_ff;
   logic                 simple_ok_ff;
   logic                 simple_ok_in;
   logic                 hit_in;

   always_comb begin
      simple_ok_in = 1'b1;
      for (int i = 0; i < AX; i++) begin
         if (!flags[i].ok) simple_ok_in = 1'b0;
         // Against the initial interval [0, 1].
         if (flags[i].active &&
             ($signed({1'b0, den[i]}) < (NW+1)'($signed(n_in[i]))))
            simple_ok_in = 1'b0;
         if (flags[i].active && n_out[i][NW-1]) simple_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable_mul) begin
         for (int i = 0; i < AX; i++) begin
            for (int j = 0; j < AX; j++) begin
               lhs_lo_ff[i][j] <= LW'($signed(n_in[i]))  * LW'($signed({1'b0, den[j][H-1:0]}));
               lhs_hi_ff[i][j] <= UW'($signed(n_in[i]))  * UW'($signed({1'b0, den[j][DW-1:H]}));
               rhs_lo_ff[i][j] <= LW'($signed(n_out[j])) * LW'($signed({1'b0, den[i][H-1:0]}));
               rhs_hi_ff[i][j] <= UW'($signed(n_out[j])) * UW'($signed({1'b0, den[i][DW-1:H]}));
            end
            active_ff[i] <= flags[i].active;
         end
         simple_ok_ff <= simple_ok_in;
      end
   end

   always_comb begin
      logic signed [PW-1:0] lhs, rhs;
      hit_in = simple_ok_ff;
      for (int i = 0; i < AX; i++) begin
         for (int j = 0; j < AX; j++) begin
            lhs = (PW'(lhs_hi_ff[i][j]) <<< H) + PW'(lhs_lo_ff[i][j]);
            rhs = (PW'(rhs_hi_ff[i][j]) <<< H) + PW'(rhs_lo_ff[i][j]);
            if (active_ff[i] && active_ff[j] && (lhs > rhs)) hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable_cmp) hit_ff <= hit_in;
   end

endmodule

// ----- design/segment_box_slab_test_unit.sv -----
// Segment versus axis-aligned box test, top level: box registers, three
// axis lanes, merge stage and pipeline control. Depends on sbst_pkg.
// An accepted request beat passes the lane, product and hit registers in turn.
// Throughput: one segment per cycle without stalls; the three-stage pipeline
// advances stage by stage and fills bubbles while the response side stalls.
// Reset (synchronous, active high) empties the pipeline and loads an empty box.
module segment_box_slab_test_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_start_x,
   input  logic signed [COORD_WIDTH-1:0]          req_start_y,
   input  logic signed [COORD_WIDTH-1:0]          req_start_z,
   input  logic signed [COORD_WIDTH-1:0]          req_end_x,
   input  logic signed [COORD_WIDTH-1:0]          req_end_y,
   input  logic signed [COORD_WIDTH-1:0]          req_end_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sbst_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_data
);

   localparam int AX = sbst_pkg::NUM_AXES;
   localparam logic [COORD_WIDTH-1:0] MOST_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] MOST_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [AX-1:0][COORD_WIDTH-1:0] box_low_ff, box_high_ff;
   logic [AX-1:0][COORD_WIDTH-1:0] start_vec, end_vec;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   logic signed [AX-1:0][COORD_WIDTH:0] n_in, n_out;
   logic        [AX-1:0][COORD_WIDTH:0] den;
   sbst_pkg::lane_flags_type [AX-1:0]   flags;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_low_ff  <= {AX{MOST_POS}};
         box_high_ff <= {AX{MOST_NEG}};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sbst_pkg::REG_BOX_LOW_X:  box_low_ff[0]  <= csr_data;
            sbst_pkg::REG_BOX_LOW_Y:  box_low_ff[1]  <= csr_data;
            sbst_pkg::REG_BOX_LOW_Z:  box_low_ff[2]  <= csr_data;
            sbst_pkg::REG_BOX_HIGH_X: box_high_ff[0] <= csr_data;
            sbst_pkg::REG_BOX_HIGH_Y: box_high_ff[1] <= csr_data;
            sbst_pkg::REG_BOX_HIGH_Z: box_high_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Each stage moves when it is empty or the stage after it moves.
   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   assign start_vec = {req_start_z, req_start_y, req_start_x};
   assign end_vec   = {req_end_z, req_end_y, req_end_x};

   for (genvar a = 0; a < AX; a++) begin : g_lane
      sbst_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
         .clock       (clock),
         .enable      (en1),
         .box_low     (box_low_ff[a]),
         .box_high    (box_high_ff[a]),
         .start_coord (start_vec[a]),
         .end_coord   (end_vec[a]),
         .n_in_ff     (n_in[a]),
         .n_out_ff    (n_out[a]),
         .den_ff      (den[a]),
         .flags_ff    (flags[a])
      );
   end

   sbst_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
      .clock      (clock),
      .enable_mul (en2),
      .enable_cmp (en3),
      .n_in       (n_in),
      .n_out      (n_out),
      .den        (den),
      .flags      (flags),
      .hit_ff     (rsp_hit)
   );

   assign rsp_valid = v3_ff;

endmodule

// ----- design/sbst_checker.sv -----
// Port-level checks for segment_box_slab_test_unit, attached by bind.
// Depends only on the top level's ports.
module sbst_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic csr_ready
);

   // A response beat waiting on a stall stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // With the output empty the pipeline can always take a request.
   assert property (@(posedge clock) !rsp_valid |-> !req_stall)
      else $error("request stalled while the output is empty");

   // Reset leaves no response pending.
   assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("response beat right after reset");

   // Register writes are never refused.
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register write refused");

endmodule

bind segment_box_slab_test_unit sbst_checker u_sbst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .csr_ready (csr_ready)
);
